FILE: sv/tgs_pkg.sv
package tgs_pkg;

  localparam int AXIS_MAX   = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int DIM_W      = 6;
  localparam int AXIS_BITS  = $clog2(AXIS_MAX);
  localparam int HALF_BITS  = AXIS_BITS - 1;
  localparam int POS_W      = AXIS_BITS + FRAC_BITS;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int NUM_BANKS  = 8;
  localparam int BANK_SEL_W = $clog2(NUM_BANKS);
  localparam int BANK_DEPTH = (AXIS_MAX * AXIS_MAX * AXIS_MAX) / NUM_BANKS;
  localparam int BANK_AW    = 3 * HALF_BITS;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_LVL_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // classified item as it waits in the queue
  typedef struct packed {
    cmd_e                 cmd;
    logic [AXIS_BITS-1:0] cx;
    logic [AXIS_BITS-1:0] cy;
    logic [AXIS_BITS-1:0] cz;
    logic [DATA_W-1:0]    value;
    logic [DATA_W-1:0]    dx;
    logic [DATA_W-1:0]    dy;
    logic [DATA_W-1:0]    dz;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] inv_cell_size;
    logic [DIM_W-1:0]  dim_x;
    logic [DIM_W-1:0]  dim_y;
    logic [DIM_W-1:0]  dim_z;
  } back_cfg_t;

  // positive part of query minus origin, zero when not above the origin
  function automatic logic [DATA_W-1:0] pos_diff(input logic [DATA_W-1:0] q,
                                                 input logic [DATA_W-1:0] org);
    logic signed [DATA_W:0] d;
    d = $signed({q[DATA_W-1], q}) - $signed({org[DATA_W-1], org});
    if (d <= 0) begin
      return '0;
    end
    return d[DATA_W-1:0];
  endfunction

  // (dim-1) << FRAC_BITS with dim clamped to [1, AXIS_MAX]
  function automatic logic [POS_W-1:0] axis_lim(input logic [DIM_W-1:0] dim);
    logic [AXIS_BITS-1:0] m1;
    if (dim == '0) begin
      m1 = '0;
    end else if (dim > DIM_W'(AXIS_MAX)) begin
      m1 = AXIS_BITS'(AXIS_MAX - 1);
    end else begin
      m1 = AXIS_BITS'(dim - 1'b1);
    end
    return {m1, {FRAC_BITS{1'b0}}};
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input logic [PROD_W-1:0] prod,
                                                 input logic [DIM_W-1:0]  dim);
    logic [POS_W-1:0]           lim;
    logic [PROD_W-FRAC_BITS-1:0] pos;
    lim = axis_lim(dim);
    pos = prod[PROD_W-1:FRAC_BITS];
    if (pos > (PROD_W-FRAC_BITS)'(lim)) begin
      return lim;
    end
    return pos[POS_W-1:0];
  endfunction

  // a*(1-f) + b*f written as a + (b-a)*f, truncated
  function automatic logic [DATA_W-1:0] blend(input logic [DATA_W-1:0]    a,
                                              input logic [DATA_W-1:0]    b,
                                              input logic [FRAC_BITS-1:0] f);
    logic signed [DATA_W:0]             diff;
    logic signed [DATA_W+FRAC_BITS+1:0] acc;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    acc  = $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + diff * $signed({1'b0, f});
    if (f == '0) begin
      return a;
    end
    return acc[DATA_W+FRAC_BITS-1:FRAC_BITS];
  endfunction

endpackage

FILE: sv/trilinear_grid_sampler.sv
// channel   direction  handshake              beat contents
// in        input      in_valid_i/in_stall_o  command, cell_x/y/z, cell_value, query_x/y/z
// out       output     out_valid_o/out_stall_i sampled_value
// cfg       input      apb psel/penable/pready origin_x/y/z, inv_cell_size, dim_x/y/z
//
// one beat per cycle in and out unless stalled; a sample passes from accept to result
// through queue, multiply, clamp with bank address and read, and three blend levels
// loads travel the same pipe and land in the store before any later sample reads it
// reset clears control only; the grid store holds nothing valid until loaded
// out_stall_i freezes the back pipe; the four-entry queue keeps taking beats until full
module trilinear_grid_sampler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [tgs_pkg::AXIS_BITS-1:0] cell_x_i,
  input  logic [tgs_pkg::AXIS_BITS-1:0] cell_y_i,
  input  logic [tgs_pkg::AXIS_BITS-1:0] cell_z_i,
  input  logic [tgs_pkg::DATA_W-1:0]    cell_value_i,
  input  logic [tgs_pkg::DATA_W-1:0]    query_x_i,
  input  logic [tgs_pkg::DATA_W-1:0]    query_y_i,
  input  logic [tgs_pkg::DATA_W-1:0]    query_z_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tgs_pkg::DATA_W-1:0]    sampled_value_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tgs_pkg::*;

  // register slots, byte address 4*i
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_INV_CELL = 3'd3;
  localparam logic [2:0] REG_DIM_X    = 3'd4;
  localparam logic [2:0] REG_DIM_Y    = 3'd5;
  localparam logic [2:0] REG_DIM_Z    = 3'd6;

  logic [DATA_W-1:0] origin_x_q, origin_y_q, origin_z_q, inv_cell_q;
  logic [DIM_W-1:0]  dim_x_q, dim_y_q, dim_z_q;
  logic [2:0]        reg_idx;
  logic              cfg_wr;

  back_cfg_t          back_cfg;
  item_t              fr_item, q_head;
  logic               q_push, q_pop, q_full, q_empty;
  logic [Q_LVL_W-1:0] q_level;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      inv_cell_q <= DATA_W'(1 << FRAC_BITS);
      dim_x_q    <= DIM_W'(2);
      dim_y_q    <= DIM_W'(2);
      dim_z_q    <= DIM_W'(2);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ORIGIN_X: origin_x_q <= pwdata;
        REG_ORIGIN_Y: origin_y_q <= pwdata;
        REG_ORIGIN_Z: origin_z_q <= pwdata;
        REG_INV_CELL: inv_cell_q <= pwdata;
        REG_DIM_X:    dim_x_q    <= pwdata[DIM_W-1:0];
        REG_DIM_Y:    dim_y_q    <= pwdata[DIM_W-1:0];
        REG_DIM_Z:    dim_z_q    <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X: prdata = origin_x_q;
      REG_ORIGIN_Y: prdata = origin_y_q;
      REG_ORIGIN_Z: prdata = origin_z_q;
      REG_INV_CELL: prdata = inv_cell_q;
      REG_DIM_X:    prdata = 32'(dim_x_q);
      REG_DIM_Y:    prdata = 32'(dim_y_q);
      REG_DIM_Z:    prdata = 32'(dim_z_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    back_cfg.inv_cell_size = inv_cell_q;
    back_cfg.dim_x         = dim_x_q;
    back_cfg.dim_y         = dim_y_q;
    back_cfg.dim_z         = dim_z_q;
  end

  // front: classify and take the offset from the origin
  tgs_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_z_i     (cell_z_i),
    .cell_value_i (cell_value_i),
    .query_x_i    (query_x_i),
    .query_y_i    (query_y_i),
    .query_z_i    (query_z_i),
    .origin_x_i   (origin_x_q),
    .origin_y_i   (origin_y_q),
    .origin_z_i   (origin_z_q),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .item_o       (fr_item)
  );

  // decoupling queue
  tgs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (fr_item),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty),
    .level_o (q_level)
  );

  // back: scale, clamp, eight-bank read, blend tree
  tgs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (back_cfg),
    .q_empty_i       (q_empty),
    .head_i          (q_head),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sampled_value_o (sampled_value_o)
  );

`ifndef SYNTH
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= Q_LVL_W'(Q_DEPTH)) else $error("queue level beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_level != '0) else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> q_level == $past(q_level) + 1'b1)
    else $error("queue level did not follow push");
`endif
endmodule

FILE: sv/tgs_ram.sv
module tgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: sv/tgs_front.sv
module tgs_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [tgs_pkg::AXIS_BITS-1:0] cell_x_i,
  input  logic [tgs_pkg::AXIS_BITS-1:0] cell_y_i,
  input  logic [tgs_pkg::AXIS_BITS-1:0] cell_z_i,
  input  logic [tgs_pkg::DATA_W-1:0]    cell_value_i,
  input  logic [tgs_pkg::DATA_W-1:0]    query_x_i,
  input  logic [tgs_pkg::DATA_W-1:0]    query_y_i,
  input  logic [tgs_pkg::DATA_W-1:0]    query_z_i,
  input  logic [tgs_pkg::DATA_W-1:0]    origin_x_i,
  input  logic [tgs_pkg::DATA_W-1:0]    origin_y_i,
  input  logic [tgs_pkg::DATA_W-1:0]    origin_z_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output tgs_pkg::item_t                item_o
);
  import tgs_pkg::*;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.cmd   = (command_i == 1'b1) ? CMD_SAMPLE : CMD_LOAD;
    item_o.cx    = cell_x_i;
    item_o.cy    = cell_y_i;
    item_o.cz    = cell_z_i;
    item_o.value = cell_value_i;
    item_o.dx    = pos_diff(query_x_i, origin_x_i);
    item_o.dy    = pos_diff(query_y_i, origin_y_i);
    item_o.dz    = pos_diff(query_z_i, origin_z_i);
  end
endmodule

FILE: sv/tgs_fifo.sv
module tgs_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  tgs_pkg::item_t              item_i,
  input  logic                        pop_i,
  output tgs_pkg::item_t              head_o,
  output logic                        full_o,
  output logic                        empty_o,
  output logic [tgs_pkg::Q_LVL_W-1:0] level_o
);
  import tgs_pkg::*;

  item_t                slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [Q_LVL_W-1:0]   lvl_q, lvl_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    lvl_d = lvl_q;
    if (push_i && !pop_i) begin
      lvl_d = lvl_q + 1'b1;
    end else if (pop_i && !push_i) begin
      lvl_d = lvl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  assign head_o  = slot_q[rd_q];
  assign full_o  = (lvl_q == Q_LVL_W'(Q_DEPTH));
  assign empty_o = (lvl_q == '0);
  assign level_o = lvl_q;
endmodule

FILE: sv/tgs_back.sv
module tgs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tgs_pkg::back_cfg_t         cfg_i,
  input  logic                       q_empty_i,
  input  tgs_pkg::item_t             head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tgs_pkg::DATA_W-1:0] sampled_value_o
);
  import tgs_pkg::*;

  logic en;

  // s1: item out of the queue
  logic  s1_vld_q;
  item_t s1_q;
  // s2: products
  logic                 s2_vld_q;
  cmd_e                 s2_cmd_q;
  logic [AXIS_BITS-1:0] s2_cx_q, s2_cy_q, s2_cz_q;
  logic [DATA_W-1:0]    s2_val_q;
  logic [PROD_W-1:0]    s2_px_q, s2_py_q, s2_pz_q;
  // s3: bank read data
  logic                 s3_vld_q;
  logic [2:0]           s3_par_q;
  logic [FRAC_BITS-1:0] s3_fx_q, s3_fy_q, s3_fz_q;
  // s4: x blends
  logic                 s4_vld_q;
  logic [DATA_W-1:0]    s4_c00_q, s4_c01_q, s4_c10_q, s4_c11_q;
  logic [FRAC_BITS-1:0] s4_fy_q, s4_fz_q;
  // s5: y blends
  logic                 s5_vld_q;
  logic [DATA_W-1:0]    s5_c0_q, s5_c1_q;
  logic [FRAC_BITS-1:0] s5_fz_q;
  // result
  logic                 out_vld_q;
  logic [DATA_W-1:0]    out_q;

  logic [POS_W-1:0]      pos_x, pos_y, pos_z;
  logic [AXIS_BITS-1:0]  ix, iy, iz;
  logic [HALF_BITS-1:0]  ex, ox, ey, oy, ez, oz;
  logic [BANK_SEL_W-1:0] ld_bank;
  logic [BANK_AW-1:0]    ld_addr;
  logic                  is_load, is_samp;
  logic [BANK_AW-1:0]    bank_addr [NUM_BANKS];
  logic                  bank_we   [NUM_BANKS];
  logic [DATA_W-1:0]     bank_rd   [NUM_BANKS];
  logic [DATA_W-1:0]     corner    [NUM_BANKS];

  assign en    = !(out_vld_q && out_stall_i);
  assign pop_o = en && !q_empty_i;

  // s2 address generation
  always_comb begin
    pos_x   = clamp_pos(s2_px_q, cfg_i.dim_x);
    pos_y   = clamp_pos(s2_py_q, cfg_i.dim_y);
    pos_z   = clamp_pos(s2_pz_q, cfg_i.dim_z);
    ix      = pos_x[POS_W-1:FRAC_BITS];
    iy      = pos_y[POS_W-1:FRAC_BITS];
    iz      = pos_z[POS_W-1:FRAC_BITS];
    // odd neighbour at i>>1, even neighbour one row up when i is odd
    ox      = ix[AXIS_BITS-1:1];
    oy      = iy[AXIS_BITS-1:1];
    oz      = iz[AXIS_BITS-1:1];
    ex      = ix[0] ? ox + 1'b1 : ox;
    ey      = iy[0] ? oy + 1'b1 : oy;
    ez      = iz[0] ? oz + 1'b1 : oz;
    ld_bank = {s2_cz_q[0], s2_cy_q[0], s2_cx_q[0]};
    ld_addr = {s2_cz_q[AXIS_BITS-1:1], s2_cy_q[AXIS_BITS-1:1], s2_cx_q[AXIS_BITS-1:1]};
    is_load = s2_vld_q && (s2_cmd_q == CMD_LOAD);
    is_samp = s2_vld_q && (s2_cmd_q == CMD_SAMPLE);
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    always_comb begin
      if (is_load) begin
        bank_addr[b] = ld_addr;
      end else begin
        bank_addr[b] = {b[2] ? oz : ez, b[1] ? oy : ey, b[0] ? ox : ex};
      end
      bank_we[b] = en && is_load && (ld_bank == BANK_SEL_W'(b));
    end

    tgs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .re_i    (en && is_samp),
      .addr_i  (bank_addr[b]),
      .wdata_i (s2_val_q),
      .rdata_o (bank_rd[b])
    );

    // corner {dz,dy,dx} lives in the bank with parity of i0 flipped by d
    assign corner[b] = bank_rd[BANK_SEL_W'(b) ^ s3_par_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= !q_empty_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= is_samp;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      out_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= head_i;
      s2_cmd_q <= s1_q.cmd;
      s2_cx_q  <= s1_q.cx;
      s2_cy_q  <= s1_q.cy;
      s2_cz_q  <= s1_q.cz;
      s2_val_q <= s1_q.value;
      s2_px_q  <= PROD_W'(s1_q.dx) * PROD_W'(cfg_i.inv_cell_size);
      s2_py_q  <= PROD_W'(s1_q.dy) * PROD_W'(cfg_i.inv_cell_size);
      s2_pz_q  <= PROD_W'(s1_q.dz) * PROD_W'(cfg_i.inv_cell_size);
      s3_par_q <= {iz[0], iy[0], ix[0]};
      s3_fx_q  <= pos_x[FRAC_BITS-1:0];
      s3_fy_q  <= pos_y[FRAC_BITS-1:0];
      s3_fz_q  <= pos_z[FRAC_BITS-1:0];
      s4_c00_q <= blend(corner[0], corner[1], s3_fx_q);
      s4_c10_q <= blend(corner[2], corner[3], s3_fx_q);
      s4_c01_q <= blend(corner[4], corner[5], s3_fx_q);
      s4_c11_q <= blend(corner[6], corner[7], s3_fx_q);
      s4_fy_q  <= s3_fy_q;
      s4_fz_q  <= s3_fz_q;
      s5_c0_q  <= blend(s4_c00_q, s4_c10_q, s4_fy_q);
      s5_c1_q  <= blend(s4_c01_q, s4_c11_q, s4_fy_q);
      s5_fz_q  <= s4_fz_q;
      out_q    <= blend(s5_c0_q, s5_c1_q, s5_fz_q);
    end
  end

  assign out_valid_o     = out_vld_q;
  assign sampled_value_o = out_q;
endmodule
